[rtl/assert_macros.svh]
// assertion helpers for the rtl, included by shx_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define SHX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising clock edge, reset included
`define SHX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/shx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package shx_pkg;

  localparam int MAX_SOURCES = 8;
  localparam int MAX_DESTS   = 8;
  localparam int LANE_DEPTH  = 16;

  localparam int SRC_W   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int DST_W   = (MAX_DESTS > 1) ? $clog2(MAX_DESTS) : 1;
  localparam int IDX_W   = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(LANE_DEPTH + 1);
  localparam int NSRC_W  = $clog2(MAX_SOURCES + 1);
  localparam int NDST_W  = $clog2(MAX_DESTS + 1);
  localparam int ADDR_W  = SRC_W + DST_W + IDX_W;
  localparam int STORE_DEPTH = MAX_SOURCES * MAX_DESTS * LANE_DEPTH;
  localparam int PAY_W   = 64;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_FETCH  = 2'd2;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_FULL     = 3'd1;
  localparam logic [2:0] STATUS_NODATA   = 3'd2;
  localparam logic [2:0] STATUS_FINISHED = 3'd3;
  localparam logic [2:0] STATUS_BADID    = 3'd4;

  localparam logic [1:0] CFG_SOURCE_COUNT  = 2'd0;
  localparam logic [1:0] CFG_DEST_COUNT    = 2'd1;
  localparam logic [1:0] CFG_LANE_CAPACITY = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  src_id;
    logic [2:0]  dst_id;
    logic [63:0] payload;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] payload_out;
    logic        lane_has_room;
  } out_t;

  typedef enum logic [2:0] {
    CMD_BAD,
    CMD_PUSH,
    CMD_FINISH,
    CMD_FETCH,
    CMD_NOSRC
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SRC_W-1:0]  src;
    logic [DST_W-1:0]  dst;
    logic              dst_ok;
    logic [PAY_W-1:0]  payload;
  } qent_t;

  typedef struct packed {
    logic [NSRC_W-1:0] nsrc;
    logic [FILL_W-1:0] cap;
    logic              clear;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

[rtl/shx_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module shx_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/shx_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module shx_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire shx_pkg::in_t  in_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [4:0]    cfg_data,
  output shx_pkg::cfg_t      cfg,
  output logic               q_valid,
  output shx_pkg::qent_t     q_head,
  input  wire logic          q_pop
);
  import shx_pkg::*;

  logic [3:0] src_cnt_r, src_cnt_nxt;
  logic [3:0] dst_cnt_r, dst_cnt_nxt;
  logic [4:0] cap_r, cap_nxt;
  logic [NSRC_W-1:0] nsrc;
  logic [NDST_W-1:0] ndst;
  logic cfg_wr;

  qent_t q_r [2];
  logic  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  qent_t ent;
  logic  push;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready;

  always_comb begin
    src_cnt_nxt = src_cnt_r;
    dst_cnt_nxt = dst_cnt_r;
    cap_nxt = cap_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        CFG_SOURCE_COUNT:  src_cnt_nxt = cfg_data[3:0];
        CFG_DEST_COUNT:    dst_cnt_nxt = cfg_data[3:0];
        CFG_LANE_CAPACITY: cap_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r <= 4'd1;
      dst_cnt_r <= 4'd1;
      cap_r <= 5'd16;
    end else begin
      src_cnt_r <= src_cnt_nxt;
      dst_cnt_r <= dst_cnt_nxt;
      cap_r <= cap_nxt;
    end
  end

  assign nsrc = (32'(src_cnt_r) > MAX_SOURCES) ? NSRC_W'(MAX_SOURCES) : NSRC_W'(src_cnt_r);
  assign ndst = (32'(dst_cnt_r) > MAX_DESTS) ? NDST_W'(MAX_DESTS) : NDST_W'(dst_cnt_r);
  assign cfg.nsrc = nsrc;
  assign cfg.cap = (32'(cap_r) > LANE_DEPTH) ? FILL_W'(LANE_DEPTH) : FILL_W'(cap_r);
  assign cfg.clear = cfg_wr &&
                     (cfg_index == CFG_SOURCE_COUNT || cfg_index == CFG_DEST_COUNT);

  // classify the incoming transaction
  always_comb begin
    logic s_ok, d_ok;
    s_ok = 32'(in_data.src_id) < 32'(nsrc);
    d_ok = 32'(in_data.dst_id) < 32'(ndst);
    ent.src = SRC_W'(in_data.src_id);
    ent.dst = DST_W'(in_data.dst_id);
    ent.dst_ok = d_ok;
    ent.payload = in_data.payload;
    ent.cmd = CMD_BAD;
    unique case (in_data.op)
      OP_PUSH:   ent.cmd = (s_ok && d_ok) ? CMD_PUSH : CMD_BAD;
      OP_FINISH: ent.cmd = s_ok ? CMD_FINISH : CMD_BAD;
      OP_FETCH: begin
        if (d_ok) begin
          ent.cmd = (nsrc == '0) ? CMD_NOSRC : CMD_FETCH;
        end
      end
      default:   ent.cmd = CMD_BAD;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= ent;
    end
  end

endmodule
`default_nettype wire

[rtl/shx_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module shx_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire shx_pkg::cfg_t  cfg,
  input  wire logic           q_valid,
  input  wire shx_pkg::qent_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output shx_pkg::out_t       out_data
);
  import shx_pkg::*;
  `include "assert_macros.svh"

  state_t state_r, state_nxt;

  logic [FILL_W-1:0] fill_r [MAX_SOURCES][MAX_DESTS];
  logic [FILL_W-1:0] fill_nxt [MAX_SOURCES][MAX_DESTS];
  logic [IDX_W-1:0]  head_r [MAX_SOURCES][MAX_DESTS];
  logic [IDX_W-1:0]  head_nxt [MAX_SOURCES][MAX_DESTS];
  logic [MAX_SOURCES-1:0] done_r, done_nxt;
  logic [NSRC_W-1:0] dcnt_r, dcnt_nxt;
  logic [SRC_W-1:0]  ptr_r [MAX_DESTS];
  logic [SRC_W-1:0]  ptr_nxt [MAX_DESTS];

  logic [2:0] rstat_r, rstat_nxt;
  logic       rroom_r, rroom_nxt;
  logic       rpop_r, rpop_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r;
  logic       load_out;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [PAY_W-1:0]  rdata;

  // round-robin pick over the lanes of one destination
  logic [SRC_W-1:0] from, from2, sel;
  logic             found;

  always_comb begin
    logic [MAX_SOURCES-1:0] m, hi;
    logic [SRC_W-1:0] p;
    logic [SRC_W-1:0] s_lo, s_hi;
    p = ptr_r[q_head.dst];
    from = (32'(p) + 1 >= 32'(cfg.nsrc)) ? '0 : SRC_W'(32'(p) + 1);
    from2 = (32'(from) + 1 >= 32'(cfg.nsrc)) ? '0 : SRC_W'(32'(from) + 1);
    s_lo = '0;
    s_hi = '0;
    for (int i = 0; i < MAX_SOURCES; i++) begin
      m[i] = (i < 32'(cfg.nsrc)) && (fill_r[i][q_head.dst] != '0);
      hi[i] = m[i] && (i >= 32'(from));
    end
    for (int i = MAX_SOURCES - 1; i >= 0; i--) begin
      if (m[i]) s_lo = SRC_W'(i);
      if (hi[i]) s_hi = SRC_W'(i);
    end
    found = |m;
    sel = (|hi) ? s_hi : s_lo;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_pop) state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: q_pop = q_valid && (!out_valid_r || !out_stall);
      ST_RESP: load_out = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    logic [FILL_W-1:0] f;
    logic [IDX_W-1:0]  h;
    logic [FILL_W:0]   t;
    fill_nxt = fill_r;
    head_nxt = head_r;
    done_nxt = done_r;
    dcnt_nxt = dcnt_r;
    ptr_nxt = ptr_r;
    rstat_nxt = rstat_r;
    rroom_nxt = rroom_r;
    rpop_nxt = rpop_r;
    we = 1'b0;
    f = fill_r[q_head.src][q_head.dst];
    h = head_r[q_head.src][q_head.dst];
    t = (FILL_W + 1)'(h) + (FILL_W + 1)'(f);
    if (32'(t) >= LANE_DEPTH) t = t - (FILL_W + 1)'(LANE_DEPTH);
    waddr = {q_head.src, q_head.dst, IDX_W'(t)};
    raddr = {sel, q_head.dst, head_r[sel][q_head.dst]};
    if (cfg.clear) begin
      for (int s = 0; s < MAX_SOURCES; s++) begin
        for (int d = 0; d < MAX_DESTS; d++) begin
          fill_nxt[s][d] = '0;
          head_nxt[s][d] = '0;
        end
      end
      for (int d = 0; d < MAX_DESTS; d++) ptr_nxt[d] = '0;
      done_nxt = '0;
      dcnt_nxt = '0;
    end else if (q_pop) begin
      rpop_nxt = 1'b0;
      rroom_nxt = 1'b0;
      unique case (q_head.cmd)
        CMD_PUSH: begin
          if (f < cfg.cap) begin
            we = 1'b1;
            fill_nxt[q_head.src][q_head.dst] = f + 1'b1;
            rstat_nxt = STATUS_OK;
            rroom_nxt = (f + 1'b1) < cfg.cap;
          end else begin
            rstat_nxt = STATUS_FULL;
          end
        end
        CMD_FINISH: begin
          if (!done_r[q_head.src]) begin
            done_nxt[q_head.src] = 1'b1;
            dcnt_nxt = dcnt_r + 1'b1;
          end
          rstat_nxt = STATUS_OK;
          rroom_nxt = q_head.dst_ok && (f < cfg.cap);
        end
        CMD_FETCH: begin
          if (found) begin
            ptr_nxt[q_head.dst] = from;
            fill_nxt[sel][q_head.dst] = fill_r[sel][q_head.dst] - 1'b1;
            head_nxt[sel][q_head.dst] =
              (32'(head_r[sel][q_head.dst]) == LANE_DEPTH - 1) ? '0 :
              head_r[sel][q_head.dst] + 1'b1;
            rstat_nxt = STATUS_OK;
            rpop_nxt = 1'b1;
            rroom_nxt = (fill_r[sel][q_head.dst] - 1'b1) < cfg.cap;
          end else if (dcnt_r != cfg.nsrc) begin
            ptr_nxt[q_head.dst] = from;
            rstat_nxt = STATUS_NODATA;
          end else begin
            ptr_nxt[q_head.dst] = from2;
            rstat_nxt = STATUS_FINISHED;
          end
        end
        CMD_NOSRC: rstat_nxt = STATUS_FINISHED;
        default:   rstat_nxt = STATUS_BADID;
      endcase
    end
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      done_r <= '0;
      dcnt_r <= '0;
      for (int s = 0; s < MAX_SOURCES; s++) begin
        for (int d = 0; d < MAX_DESTS; d++) begin
          fill_r[s][d] <= '0;
          head_r[s][d] <= '0;
        end
      end
      for (int d = 0; d < MAX_DESTS; d++) ptr_r[d] <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      done_r <= done_nxt;
      dcnt_r <= dcnt_nxt;
      fill_r <= fill_nxt;
      head_r <= head_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rstat_r <= rstat_nxt;
    rroom_r <= rroom_nxt;
    rpop_r <= rpop_nxt;
    if (load_out) begin
      out_data_r.status <= rstat_r;
      out_data_r.payload_out <= rpop_r ? rdata : '0;
      out_data_r.lane_has_room <= rroom_r;
    end
  end

  shx_ram #(
    .WIDTH(PAY_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(q_head.payload),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  `SHX_ASSERT(a_pop_idle, q_pop |-> state_r == ST_IDLE, "pop outside idle")
  `SHX_ASSERT(a_resp_empty, state_r == ST_RESP |-> !out_valid_r, "response over held result")
  `SHX_ASSERT(a_dcnt_range, dcnt_r <= cfg.nsrc, "done count above source count")
  `SHX_ASSERT(a_resp_after_pop, q_pop |=> load_out, "popped transaction not answered")

endmodule
`default_nettype wire

[rtl/shuffle_crossbar_queues.sv]
// shuffle_crossbar_queues: round-robin crossbar of bounded lanes, one per
// source and destination pair.
// input channel: in_valid / in_stall / in_data (op, src_id, dst_id, payload).
//   a transaction moves when in_valid is high and in_stall is low.
// result channel: out_valid / out_stall / out_data (status, payload_out,
//   lane_has_room), exactly one result per input transaction, in order.
// config channel: cfg_valid / cfg_ready / cfg_index / cfg_data; index 0
//   source count, 1 destination count, 2 lane capacity. writing either
//   count empties all lanes and clears done flags and pointers. write only
//   while no transaction is in flight.
// execute: a transaction is registered in the queue, popped in the idle
//   state, which updates lane state and addresses the payload memory, then
//   the resp state registers the read data into the result. no new
//   transaction is popped while the sequencer is in resp.
// a two-entry queue sits between the classifier and the executor, so input
//   keeps flowing while a result waits; when out_stall holds, the queue fills
//   and in_stall rises.
// reset (rst_n low, synchronous): counts return to 1/1/16, all lanes empty.
`timescale 1ns / 1ps
`default_nettype none
module shuffle_crossbar_queues (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire shx_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output shx_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [4:0]    cfg_data
);
  import shx_pkg::*;

  cfg_t  cfg;
  logic  q_valid, q_pop;
  qent_t q_head;

  shx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  shx_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
